[hw/rtl/gbs_pkg.sv]
// Shared types, constants and register codes for the grid bilinear sampler.
// Used by every module in hw/rtl except gbs_ram; depends on nothing.
package gbs_pkg;

  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 64;
  localparam int CNT_W      = 7;
  localparam int VAL_W      = 32;
  localparam int LIDX_W     = 12;
  localparam int GRID_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W     = $clog2(GRID_DEPTH);
  localparam int IDX_W      = $clog2((MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS);
  localparam int FRAC_W     = 16;
  localparam int Q_ONE      = 1 << FRAC_W;

  // Divider pipelines: quotient bits retired per stage.
  localparam int STEP_PER   = 2;
  localparam int REM_W      = VAL_W - 1;
  localparam int LDIV_N     = IDX_W + FRAC_W;
  localparam int LOC_STG    = (LDIV_N + STEP_PER - 1) / STEP_PER;
  localparam int SDIV_N     = VAL_W;
  localparam int SLP_STG    = (SDIV_N + STEP_PER - 1) / STEP_PER;
  localparam int MAG_W      = VAL_W + FRAC_W;
  localparam int PROD_W     = MAG_W + 2;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    REG_COLS   = 3'd0,
    REG_ROWS   = 3'd1,
    REG_STEP_X = 3'd2,
    REG_STEP_Y = 3'd3,
    REG_X_LO   = 3'd4,
    REG_X_HI   = 3'd5,
    REG_Y_LO   = 3'd6,
    REG_Y_HI   = 3'd7
  } gbs_reg_t;

  typedef struct packed {
    logic                     mode;
    logic [LIDX_W-1:0]        load_index;
    logic signed [VAL_W-1:0]  load_height;
    logic signed [VAL_W-1:0]  pos_x;
    logic signed [VAL_W-1:0]  pos_y;
  } gbs_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  height;
    logic signed [VAL_W-1:0]  slope_x;
    logic signed [VAL_W-1:0]  slope_y;
  } gbs_out_t;

  typedef struct packed {
    logic              smp;
    logic              ok;
    logic [LIDX_W-1:0] ld_idx;
    logic [VAL_W-1:0]  ld_val;
  } gbs_loc_side_t;

  typedef struct packed {
    gbs_loc_side_t         side;
    logic [1:0][VAL_W-1:0] off;
  } gbs_loc_in_t;

  typedef struct packed {
    gbs_loc_side_t          side;
    logic [1:0][IDX_W-1:0]  idx;
    logic [1:0][FRAC_W:0]   frac;
  } gbs_loc_out_t;

  typedef struct packed {
    logic                   ok;
    logic [VAL_W-1:0]       height;
    logic [1:0][PROD_W-1:0] num;
  } gbs_slp_in_t;

endpackage

[hw/rtl/gbs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module gbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/gbs_locate.sv]
// Pipelined cell locator: divides both axis offsets by the step, two
// quotient bits per stage, then clamps cell index and fraction. Uses gbs_pkg.
module gbs_locate (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  gbs_pkg::gbs_loc_in_t                in_data,
  input  logic [1:0][gbs_pkg::VAL_W-1:0]      step,
  input  logic [1:0][gbs_pkg::CNT_W-1:0]      cnt,
  output logic                                out_vld,
  output gbs_pkg::gbs_loc_out_t               out_data
);

  typedef struct packed {
    logic [gbs_pkg::REM_W-1:0]  rem;
    logic [gbs_pkg::LDIV_N-1:0] nq;
  } ldiv_t;

  function automatic ldiv_t ldiv(input ldiv_t s, input logic [gbs_pkg::REM_W-1:0] d);
    logic [gbs_pkg::REM_W:0] t;
    ldiv_t r;
    t = {s.rem, s.nq[gbs_pkg::LDIV_N-1]};
    if (t >= {1'b0, d}) begin
      r.rem = gbs_pkg::REM_W'(t - {1'b0, d});
      r.nq  = {s.nq[gbs_pkg::LDIV_N-2:0], 1'b1};
    end else begin
      r.rem = t[gbs_pkg::REM_W-1:0];
      r.nq  = {s.nq[gbs_pkg::LDIV_N-2:0], 1'b0};
    end
    return r;
  endfunction

  logic                  vld_r  [gbs_pkg::LOC_STG+1];
  gbs_pkg::gbs_loc_side_t side_r [gbs_pkg::LOC_STG+1];
  logic [1:0]            sat_r  [gbs_pkg::LOC_STG+1];
  ldiv_t                 div_r   [gbs_pkg::LOC_STG+1][2];
  ldiv_t                 div_nxt [gbs_pkg::LOC_STG+1][2];
  logic [1:0]            sat_nxt;
  logic                  out_vld_r;
  gbs_pkg::gbs_loc_out_t out_r, out_nxt;
  logic [gbs_pkg::REM_W-1:0] dvs [2];

  always_comb begin
    ldiv_t cur;
    for (int a = 0; a < 2; a++) begin
      dvs[a] = step[a][gbs_pkg::REM_W-1:0];
      // quotient above the index field means the cell clamps anyway
      div_nxt[0][a].rem = gbs_pkg::REM_W'(in_data.off[a][gbs_pkg::VAL_W-1:gbs_pkg::IDX_W]);
      div_nxt[0][a].nq  = {in_data.off[a][gbs_pkg::IDX_W-1:0], {gbs_pkg::FRAC_W{1'b0}}};
      sat_nxt[a] = div_nxt[0][a].rem >= dvs[a];
      for (int k = 1; k <= gbs_pkg::LOC_STG; k++) begin
        cur = div_r[k-1][a];
        for (int j = 0; j < gbs_pkg::STEP_PER; j++) begin
          if ((k - 1) * gbs_pkg::STEP_PER + j < gbs_pkg::LDIV_N) begin
            cur = ldiv(cur, dvs[a]);
          end
        end
        div_nxt[k][a] = cur;
      end
    end
  end

  always_comb begin
    logic [gbs_pkg::IDX_W-1:0]  i;
    logic [gbs_pkg::IDX_W-1:0]  cm2;
    logic [gbs_pkg::FRAC_W:0]   f;
    out_nxt.side = side_r[gbs_pkg::LOC_STG];
    for (int a = 0; a < 2; a++) begin
      i   = div_r[gbs_pkg::LOC_STG][a].nq[gbs_pkg::LDIV_N-1:gbs_pkg::FRAC_W];
      f   = {1'b0, div_r[gbs_pkg::LOC_STG][a].nq[gbs_pkg::FRAC_W-1:0]};
      cm2 = gbs_pkg::IDX_W'(cnt[a] - gbs_pkg::CNT_W'(2));
      // past the last cell: pin to the last cell and hold the edge value
      if (sat_r[gbs_pkg::LOC_STG][a] || i > cm2) begin
        i = cm2;
        f = (gbs_pkg::FRAC_W+1)'(gbs_pkg::Q_ONE);
      end
      out_nxt.idx[a]  = i;
      out_nxt.frac[a] = f;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= gbs_pkg::LOC_STG; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_vld_r <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 1; k <= gbs_pkg::LOC_STG; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_vld_r <= vld_r[gbs_pkg::LOC_STG];
    end
  end

  always_ff @(posedge clk) begin
    div_r     <= div_nxt;
    side_r[0] <= in_data.side;
    sat_r[0]  <= sat_nxt;
    for (int k = 1; k <= gbs_pkg::LOC_STG; k++) begin
      side_r[k] <= side_r[k-1];
      sat_r[k]  <= sat_r[k-1];
    end
    out_r <= out_nxt;
  end

  assign out_vld  = out_vld_r;
  assign out_data = out_r;

endmodule

[hw/rtl/gbs_slope.sv]
// Pipelined signed divide of both gradient numerators by the step, two
// quotient bits per stage, with saturation and result gating. Uses gbs_pkg.
module gbs_slope (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  gbs_pkg::gbs_slp_in_t            in_data,
  input  logic [1:0][gbs_pkg::VAL_W-1:0]  step,
  output logic                            out_vld,
  output gbs_pkg::gbs_out_t               out_data
);

  typedef struct packed {
    logic [gbs_pkg::REM_W-1:0]  rem;
    logic [gbs_pkg::SDIV_N-1:0] nq;
  } sdiv_t;

  typedef struct packed {
    logic                      ok;
    logic [gbs_pkg::VAL_W-1:0] height;
    logic [1:0]                neg;
    logic [1:0]                ovf;
  } side_t;

  function automatic sdiv_t sdiv(input sdiv_t s, input logic [gbs_pkg::REM_W-1:0] d);
    logic [gbs_pkg::REM_W:0] t;
    sdiv_t r;
    t = {s.rem, s.nq[gbs_pkg::SDIV_N-1]};
    if (t >= {1'b0, d}) begin
      r.rem = gbs_pkg::REM_W'(t - {1'b0, d});
      r.nq  = {s.nq[gbs_pkg::SDIV_N-2:0], 1'b1};
    end else begin
      r.rem = t[gbs_pkg::REM_W-1:0];
      r.nq  = {s.nq[gbs_pkg::SDIV_N-2:0], 1'b0};
    end
    return r;
  endfunction

  localparam logic [gbs_pkg::VAL_W-1:0] SAT_MAX = {1'b0, {(gbs_pkg::VAL_W-1){1'b1}}};
  localparam logic [gbs_pkg::VAL_W-1:0] SAT_MIN = {1'b1, {(gbs_pkg::VAL_W-1){1'b0}}};

  logic              vld_r  [gbs_pkg::SLP_STG+1];
  side_t             side_r [gbs_pkg::SLP_STG+1];
  side_t             side_nxt;
  sdiv_t             div_r   [gbs_pkg::SLP_STG+1][2];
  sdiv_t             div_nxt [gbs_pkg::SLP_STG+1][2];
  logic              out_vld_r;
  gbs_pkg::gbs_out_t out_r, out_nxt;
  logic [gbs_pkg::REM_W-1:0] dvs [2];

  always_comb begin
    logic [gbs_pkg::PROD_W-1:0] mag;
    sdiv_t cur;
    side_nxt.ok     = in_data.ok;
    side_nxt.height = in_data.height;
    for (int a = 0; a < 2; a++) begin
      dvs[a] = step[a][gbs_pkg::REM_W-1:0];
      side_nxt.neg[a] = in_data.num[a][gbs_pkg::PROD_W-1];
      mag = side_nxt.neg[a] ? (~in_data.num[a] + 1'b1) : in_data.num[a];
      div_nxt[0][a].rem = gbs_pkg::REM_W'(mag[gbs_pkg::MAG_W-1:gbs_pkg::SDIV_N]);
      div_nxt[0][a].nq  = mag[gbs_pkg::SDIV_N-1:0];
      // quotient would not fit the magnitude field
      side_nxt.ovf[a] = div_nxt[0][a].rem >= dvs[a];
      for (int k = 1; k <= gbs_pkg::SLP_STG; k++) begin
        cur = div_r[k-1][a];
        for (int j = 0; j < gbs_pkg::STEP_PER; j++) begin
          if ((k - 1) * gbs_pkg::STEP_PER + j < gbs_pkg::SDIV_N) begin
            cur = sdiv(cur, dvs[a]);
          end
        end
        div_nxt[k][a] = cur;
      end
    end
  end

  always_comb begin
    logic [gbs_pkg::VAL_W-1:0] q;
    logic [gbs_pkg::VAL_W-1:0] res [2];
    side_t s;
    s = side_r[gbs_pkg::SLP_STG];
    for (int a = 0; a < 2; a++) begin
      q = div_r[gbs_pkg::SLP_STG][a].nq;
      if (s.neg[a]) begin
        res[a] = (s.ovf[a] || q > SAT_MIN) ? SAT_MIN : (~q + 1'b1);
      end else begin
        res[a] = (s.ovf[a] || q[gbs_pkg::VAL_W-1]) ? SAT_MAX : q;
      end
    end
    // drop everything to zero on bad geometry
    out_nxt.height  = s.ok ? s.height : '0;
    out_nxt.slope_x = s.ok ? res[0] : '0;
    out_nxt.slope_y = s.ok ? res[1] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= gbs_pkg::SLP_STG; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_vld_r <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 1; k <= gbs_pkg::SLP_STG; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_vld_r <= vld_r[gbs_pkg::SLP_STG];
    end
  end

  always_ff @(posedge clk) begin
    div_r     <= div_nxt;
    side_r[0] <= side_nxt;
    for (int k = 1; k <= gbs_pkg::SLP_STG; k++) begin
      side_r[k] <= side_r[k-1];
    end
    out_r <= out_nxt;
  end

  assign out_vld  = out_vld_r;
  assign out_data = out_r;

endmodule

[hw/rtl/grid_bilinear_sample_gradient_top.sv]
// Grid bilinear sampler with gradient: top level.
// Throughput: one item (load or sample) per cycle; busy is never raised, the
// pipelined dividers (two quotient bits a stage) set the depth, not the rate.
// Reset (synchronous, rst_n low) clears config registers and all valid bits;
// grid contents are not cleared. Loads produce no result.
module grid_bilinear_sample_gradient_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  gbs_pkg::gbs_in_t           in_data,
  output logic                       out_strobe,
  output gbs_pkg::gbs_out_t          out_data,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_addr,
  input  logic [gbs_pkg::VAL_W-1:0]  cfg_wdata
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [gbs_pkg::CNT_W-1:0]        cols_r, rows_r;
  logic signed [gbs_pkg::VAL_W-1:0] step_x_r, step_y_r;
  logic signed [gbs_pkg::VAL_W-1:0] x_lo_r, x_hi_r, y_lo_r, y_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r   <= '0;
      rows_r   <= '0;
      step_x_r <= '0;
      step_y_r <= '0;
      x_lo_r   <= '0;
      x_hi_r   <= '0;
      y_lo_r   <= '0;
      y_hi_r   <= '0;
    end else if (cfg_we) begin
      unique case (gbs_pkg::gbs_reg_t'(cfg_addr))
        gbs_pkg::REG_COLS:   cols_r   <= cfg_wdata[gbs_pkg::CNT_W-1:0];
        gbs_pkg::REG_ROWS:   rows_r   <= cfg_wdata[gbs_pkg::CNT_W-1:0];
        gbs_pkg::REG_STEP_X: step_x_r <= cfg_wdata;
        gbs_pkg::REG_STEP_Y: step_y_r <= cfg_wdata;
        gbs_pkg::REG_X_LO:   x_lo_r   <= cfg_wdata;
        gbs_pkg::REG_X_HI:   x_hi_r   <= cfg_wdata;
        gbs_pkg::REG_Y_LO:   y_lo_r   <= cfg_wdata;
        gbs_pkg::REG_Y_HI:   y_hi_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Counts above the grid size act as the grid size.
  logic [gbs_pkg::CNT_W-1:0] cols_eff, rows_eff;
  logic                      geo_ok;

  assign cols_eff = (cols_r > gbs_pkg::CNT_W'(gbs_pkg::MAX_COLS)) ?
                    gbs_pkg::CNT_W'(gbs_pkg::MAX_COLS) : cols_r;
  assign rows_eff = (rows_r > gbs_pkg::CNT_W'(gbs_pkg::MAX_ROWS)) ?
                    gbs_pkg::CNT_W'(gbs_pkg::MAX_ROWS) : rows_r;
  assign geo_ok   = (cols_eff >= gbs_pkg::CNT_W'(2)) && (rows_eff >= gbs_pkg::CNT_W'(2)) &&
                    (step_x_r > 0) && (step_y_r > 0);

  // The pipeline never stalls: every start is taken.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Stage 1: capture the item
  // ---------------------------------------------------------------------
  logic             s1_vld_r;
  gbs_pkg::gbs_in_t s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= in_data;
  end

  // ---------------------------------------------------------------------
  // Stage 2: clamp to the window and form offsets from the lower bound.
  // The lower bound wins when the window is inverted.
  // ---------------------------------------------------------------------
  logic                 s2_vld_r;
  gbs_pkg::gbs_loc_in_t s2_r, s2_nxt;

  always_comb begin
    logic signed [gbs_pkg::VAL_W-1:0] x, y;
    x = s1_r.pos_x;
    if (x > x_hi_r) x = x_hi_r;
    if (x < x_lo_r) x = x_lo_r;
    y = s1_r.pos_y;
    if (y > y_hi_r) y = y_hi_r;
    if (y < y_lo_r) y = y_lo_r;
    s2_nxt.off[0]      = gbs_pkg::VAL_W'(x - x_lo_r);
    s2_nxt.off[1]      = gbs_pkg::VAL_W'(y - y_lo_r);
    s2_nxt.side.smp    = (s1_r.mode == gbs_pkg::MODE_SAMPLE);
    s2_nxt.side.ok     = geo_ok;
    s2_nxt.side.ld_idx = s1_r.load_index;
    s2_nxt.side.ld_val = s1_r.load_height;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

  // ---------------------------------------------------------------------
  // Cell index and fraction on both axes
  // ---------------------------------------------------------------------
  logic                  loc_vld;
  gbs_pkg::gbs_loc_out_t loc_out;

  gbs_locate u_locate (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s2_vld_r),
    .in_data  (s2_r),
    .step     ({step_y_r, step_x_r}),
    .cnt      ({rows_eff, cols_eff}),
    .out_vld  (loc_vld),
    .out_data (loc_out)
  );

  // ---------------------------------------------------------------------
  // Grid store: four copies so the four corners read in the same cycle.
  // Loads write here, in item order with the sample reads.
  // Corner order: w00, w10, w01, w11.
  // ---------------------------------------------------------------------
  localparam int BASE_W = gbs_pkg::IDX_W + gbs_pkg::CNT_W;

  logic [BASE_W-1:0]              base_w;
  logic [gbs_pkg::ADDR_W-1:0]     raddr [4];
  logic [gbs_pkg::VAL_W-1:0]      rdata [4];
  logic                           grid_we;
  logic [gbs_pkg::ADDR_W-1:0]     grid_waddr;

  assign base_w = BASE_W'(loc_out.idx[1]) * BASE_W'(cols_eff) + BASE_W'(loc_out.idx[0]);
  assign raddr[0] = gbs_pkg::ADDR_W'(base_w);
  assign raddr[1] = gbs_pkg::ADDR_W'(base_w + BASE_W'(1));
  assign raddr[2] = gbs_pkg::ADDR_W'(base_w + BASE_W'(cols_eff));
  assign raddr[3] = gbs_pkg::ADDR_W'(base_w + BASE_W'(cols_eff) + BASE_W'(1));

  // Drop loads that point past the grid.
  assign grid_we    = loc_vld && !loc_out.side.smp &&
                      (32'(loc_out.side.ld_idx) < 32'(gbs_pkg::GRID_DEPTH));
  assign grid_waddr = gbs_pkg::ADDR_W'(loc_out.side.ld_idx);

  for (genvar c = 0; c < 4; c++) begin : g_bank
    gbs_ram #(
      .WIDTH (gbs_pkg::VAL_W),
      .DEPTH (gbs_pkg::GRID_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (grid_we),
      .waddr (grid_waddr),
      .wdata (loc_out.side.ld_val),
      .raddr (raddr[c]),
      .rdata (rdata[c])
    );
  end

  // Stage P: alongside the RAM read register; only samples stay valid.
  logic                      p_vld_r, p_ok_r;
  logic [gbs_pkg::FRAC_W:0]  p_tx_r, p_ty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= loc_vld && loc_out.side.smp;
    end
  end

  always_ff @(posedge clk) begin
    p_ok_r <= loc_out.side.ok;
    p_tx_r <= loc_out.frac[0];
    p_ty_r <= loc_out.frac[1];
  end

  // ---------------------------------------------------------------------
  // Stage M: weight products for the row blends and gradient numerators
  // ---------------------------------------------------------------------
  localparam logic [gbs_pkg::FRAC_W:0] ONE_Q = (gbs_pkg::FRAC_W+1)'(gbs_pkg::Q_ONE);

  logic signed [gbs_pkg::PROD_W-1:0] m_p_r [8];
  logic signed [gbs_pkg::PROD_W-1:0] m_p_nxt [8];
  logic                              m_vld_r, m_ok_r;
  logic [gbs_pkg::FRAC_W:0]          m_ty_r;

  always_comb begin
    logic signed [gbs_pkg::FRAC_W+1:0] tx, ux, ty, uy;
    logic signed [gbs_pkg::VAL_W:0]    w [4];
    tx = $signed({1'b0, p_tx_r});
    ux = $signed({1'b0, ONE_Q - p_tx_r});
    ty = $signed({1'b0, p_ty_r});
    uy = $signed({1'b0, ONE_Q - p_ty_r});
    for (int c = 0; c < 4; c++) begin
      w[c] = $signed({rdata[c][gbs_pkg::VAL_W-1], rdata[c]});
    end
    m_p_nxt[0] = ux * w[0];
    m_p_nxt[1] = tx * w[1];
    m_p_nxt[2] = ux * w[2];
    m_p_nxt[3] = tx * w[3];
    m_p_nxt[4] = (w[1] - w[0]) * uy;
    m_p_nxt[5] = (w[3] - w[2]) * ty;
    m_p_nxt[6] = (w[2] - w[0]) * ux;
    m_p_nxt[7] = (w[3] - w[1]) * tx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    m_p_r  <= m_p_nxt;
    m_ok_r <= p_ok_r;
    m_ty_r <= p_ty_r;
  end

  // ---------------------------------------------------------------------
  // Stage N: row blends (floor by shift) and gradient numerator sums
  // ---------------------------------------------------------------------
  logic signed [gbs_pkg::PROD_W-1:0] sum_w0, sum_w1;
  logic [gbs_pkg::VAL_W-1:0]         n_w_r [2];
  logic [gbs_pkg::PROD_W-1:0]        n_num_r [2];
  logic                              n_vld_r, n_ok_r;
  logic [gbs_pkg::FRAC_W:0]          n_ty_r;

  assign sum_w0 = m_p_r[0] + m_p_r[1];
  assign sum_w1 = m_p_r[2] + m_p_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_vld_r <= 1'b0;
    end else begin
      n_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    n_w_r[0]   <= sum_w0[gbs_pkg::MAG_W-1:gbs_pkg::FRAC_W];
    n_w_r[1]   <= sum_w1[gbs_pkg::MAG_W-1:gbs_pkg::FRAC_W];
    n_num_r[0] <= m_p_r[4] + m_p_r[5];
    n_num_r[1] <= m_p_r[6] + m_p_r[7];
    n_ok_r     <= m_ok_r;
    n_ty_r     <= m_ty_r;
  end

  // ---------------------------------------------------------------------
  // Stage O: column blend products
  // ---------------------------------------------------------------------
  logic signed [gbs_pkg::PROD_W-1:0] o_h_r [2];
  logic [gbs_pkg::PROD_W-1:0]        o_num_r [2];
  logic                              o_vld_r, o_ok_r;
  logic signed [gbs_pkg::FRAC_W+1:0] n_ty_s, n_uy_s;

  assign n_ty_s = $signed({1'b0, n_ty_r});
  assign n_uy_s = $signed({1'b0, ONE_Q - n_ty_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= n_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    o_h_r[0] <= n_uy_s * $signed(n_w_r[0]);
    o_h_r[1] <= n_ty_s * $signed(n_w_r[1]);
    o_num_r  <= n_num_r;
    o_ok_r   <= n_ok_r;
  end

  // ---------------------------------------------------------------------
  // Stage Q: height (a convex blend, so it always fits)
  // ---------------------------------------------------------------------
  logic signed [gbs_pkg::PROD_W-1:0] sum_h;
  logic                              q_vld_r;
  gbs_pkg::gbs_slp_in_t              q_r;

  assign sum_h = o_h_r[0] + o_h_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= 1'b0;
    end else begin
      q_vld_r <= o_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    q_r.ok     <= o_ok_r;
    q_r.height <= sum_h[gbs_pkg::MAG_W-1:gbs_pkg::FRAC_W];
    q_r.num[0] <= o_num_r[0];
    q_r.num[1] <= o_num_r[1];
  end

  // ---------------------------------------------------------------------
  // Gradient divide, saturation and final result register
  // ---------------------------------------------------------------------
  gbs_slope u_slope (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (q_vld_r),
    .in_data  (q_r),
    .step     ({step_y_r, step_x_r}),
    .out_vld  (out_strobe),
    .out_data (out_data)
  );

endmodule

[tb/sv/grid_bilinear_sample_gradient_top_tb.sv]
// Self-checking bench for grid_bilinear_sample_gradient_top: loads height grids,
// samples them under many window/step settings and checks every result item.
// Depends on gbs_pkg and the RTL under hw/rtl only.
`timescale 1ns / 1ps

module grid_bilinear_sample_gradient_top_tb;

  localparam int LATENCY     = 37;
  localparam int DRAIN       = LATENCY + 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_PHASES    = 14;
  localparam int SAMPLES_PER = 50;
  localparam int LOAD_CAP    = 20;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  gbs_pkg::gbs_in_t          in_data = '0;
  logic                      out_strobe;
  gbs_pkg::gbs_out_t         out_data;
  logic                      cfg_we = 1'b0;
  logic [2:0]                cfg_addr = '0;
  logic [gbs_pkg::VAL_W-1:0] cfg_wdata = '0;

  grid_bilinear_sample_gradient_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Shadow copy of the block: registers and the height grid.
  longint grid_cols_m, grid_rows_m, step_x_m, step_y_m;
  longint x_lo_m, x_hi_m, y_lo_m, y_hi_m;
  longint heights[gbs_pkg::GRID_DEPTH];
  bit     loaded[gbs_pkg::GRID_DEPTH];

  gbs_pkg::gbs_out_t pending_samples[$];
  int                errors = 0;
  int                cycles = 0;
  bit                calm = 1'b0;   // no idling in the last phase

  // Directed rows: typed expectation where it is obvious.
  typedef struct {
    gbs_pkg::gbs_in_t  item;
    bit                typed;
    gbs_pkg::gbs_out_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void add_row(gbs_pkg::gbs_in_t it, bit typed, gbs_pkg::gbs_out_t want);
    dir_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic gbs_pkg::gbs_in_t mk_load(int idx, int h);
    gbs_pkg::gbs_in_t it;
    it = '0;
    it.mode        = gbs_pkg::MODE_LOAD;
    it.load_index  = idx[gbs_pkg::LIDX_W-1:0];
    it.load_height = h;
    it.pos_x       = $urandom;
    it.pos_y       = $urandom;
    return it;
  endfunction

  function automatic gbs_pkg::gbs_in_t mk_sample(int px, int py);
    gbs_pkg::gbs_in_t it;
    it = '0;
    it.mode        = gbs_pkg::MODE_SAMPLE;
    it.load_index  = $urandom;
    it.load_height = $urandom;
    it.pos_x       = px;
    it.pos_y       = py;
    return it;
  endfunction

  function automatic logic [gbs_pkg::VAL_W-1:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[gbs_pkg::VAL_W-1:0];
  endfunction

  function automatic int clip32(longint v);
    return int'(sat32(v));
  endfunction

  // Cell index and Q16 fraction along one axis.
  function automatic void find_cell(input longint off, input longint stp, input longint cnt,
                                    output longint idx, output longint frac);
    idx = off / stp;
    if (idx > cnt - 2) idx = cnt - 2;
    frac = ((off - idx * stp) * 65536) / stp;
    if (frac > 65536) frac = 65536;
  endfunction

  function automatic gbs_pkg::gbs_out_t interpolate(longint px, longint py);
    gbs_pkg::gbs_out_t r;
    longint c, rw, x, y, ix, iy, tx, ty, base;
    longint w00, w10, w01, w11, w0, w1, h, gx, gy;
    r = '0;
    c  = (grid_cols_m > gbs_pkg::MAX_COLS) ? gbs_pkg::MAX_COLS : grid_cols_m;
    rw = (grid_rows_m > gbs_pkg::MAX_ROWS) ? gbs_pkg::MAX_ROWS : grid_rows_m;
    if (c < 2 || rw < 2 || step_x_m <= 0 || step_y_m <= 0) return r;
    x = px; if (x > x_hi_m) x = x_hi_m; if (x < x_lo_m) x = x_lo_m;
    y = py; if (y > y_hi_m) y = y_hi_m; if (y < y_lo_m) y = y_lo_m;
    find_cell(x - x_lo_m, step_x_m, c, ix, tx);
    find_cell(y - y_lo_m, step_y_m, rw, iy, ty);
    base = iy * c + ix;
    w00 = heights[base];
    w10 = heights[base + 1];
    w01 = heights[base + c];
    w11 = heights[base + c + 1];
    w0 = ((65536 - tx) * w00 + tx * w10) >>> 16;
    w1 = ((65536 - tx) * w01 + tx * w11) >>> 16;
    h  = ((65536 - ty) * w0 + ty * w1) >>> 16;
    gx = ((w10 - w00) * (65536 - ty) + (w11 - w01) * ty) / step_x_m;
    gy = ((w01 - w00) * (65536 - tx) + (w11 - w10) * tx) / step_y_m;
    r.height  = sat32(h);
    r.slope_x = sat32(gx);
    r.slope_y = sat32(gy);
    return r;
  endfunction

  // Hold start until the item is taken, then advance the shadow model.
  task automatic send(gbs_pkg::gbs_in_t it, bit typed, gbs_pkg::gbs_out_t want);
    int gap;
    in_data <= it;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (it.mode == gbs_pkg::MODE_LOAD) begin
      heights[it.load_index] = longint'(it.load_height);
      loaded[it.load_index]  = 1'b1;
    end else begin
      pending_samples.insert(pending_samples.size(),
                             typed ? want : interpolate(it.pos_x, it.pos_y));
    end
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_plain(gbs_pkg::gbs_in_t it);
    send(it, 1'b0, '0);
  endtask

  task automatic write_reg(gbs_pkg::gbs_reg_t r, int v);
    cfg_we    <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= v;
    @(posedge clk);
    case (r)
      gbs_pkg::REG_COLS:   grid_cols_m = v & 32'h7F;
      gbs_pkg::REG_ROWS:   grid_rows_m = v & 32'h7F;
      gbs_pkg::REG_STEP_X: step_x_m = longint'(v);
      gbs_pkg::REG_STEP_Y: step_y_m = longint'(v);
      gbs_pkg::REG_X_LO:   x_lo_m = longint'(v);
      gbs_pkg::REG_X_HI:   x_hi_m = longint'(v);
      gbs_pkg::REG_Y_LO:   y_lo_m = longint'(v);
      gbs_pkg::REG_Y_HI:   y_hi_m = longint'(v);
      default: ;
    endcase
  endtask

  // Wait for all results, then let loads still in flight settle.
  task automatic drain();
    start <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic int rand_height();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return int'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
    endcase
  endfunction

  // Pick geometry for a phase; the first few hit the extremes and odd cases.
  task automatic set_geometry(int ph);
    int c, rw, sx, sy, xl, xh, yl, yh;
    c  = $urandom_range(2, 9);
    rw = $urandom_range(2, 9);
    sx = $urandom_range(1, 32'h0004_0000);
    sy = $urandom_range(1, 32'h0004_0000);
    xl = int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
    yl = int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
    xh = clip32(longint'(xl) + longint'(sx) * (c - 1));
    yh = clip32(longint'(yl) + longint'(sy) * (rw - 1));
    case (ph)
      0: begin  // full grid, widest steps and window
        c = 64; rw = 64; sx = 32'h7FFF_FFFF; sy = 32'h7FFF_FFFF;
        xl = 32'h8000_0000; xh = 32'h7FFF_FFFF; yl = 32'h8000_0000; yh = 32'h7FFF_FFFF;
      end
      1: begin  // counts above the maximum, unit step, last column reachable
        c = 127; rw = 100; sx = 1; sy = 1;
        xh = xl + 63; yh = yl + 1;
      end
      2: c = $urandom_range(0, 1);              // too few columns
      3: rw = $urandom_range(0, 1);             // too few rows
      4: sx = -$urandom_range(0, 32'h7FFF_FFFF); // non-positive step
      5: sy = 32'h8000_0000;
      6: begin  // inverted windows
        xh = xl - $urandom_range(1, 1000);
        yh = yl - $urandom_range(1, 1000);
      end
      7: begin  // window wider than the grid: edge is held
        xh = clip32(longint'(xh) + $urandom_range(1, 32'h0100_0000));
        yh = clip32(longint'(yh) + $urandom_range(1, 32'h0100_0000));
      end
      default: begin
        if ($urandom_range(0, 2) == 0) xh = clip32(longint'(xh) + $urandom_range(0, sx));
        if ($urandom_range(0, 2) == 0) yh = clip32(longint'(yh) - $urandom_range(0, sy));
      end
    endcase
    write_reg(gbs_pkg::REG_COLS, c);
    write_reg(gbs_pkg::REG_ROWS, rw);
    write_reg(gbs_pkg::REG_STEP_X, sx);
    write_reg(gbs_pkg::REG_STEP_Y, sy);
    write_reg(gbs_pkg::REG_X_LO, xl);
    write_reg(gbs_pkg::REG_X_HI, xh);
    write_reg(gbs_pkg::REG_Y_LO, yl);
    write_reg(gbs_pkg::REG_Y_HI, yh);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int rand_pos(longint lo, longint hi);
    longint span, p;
    if ($urandom_range(0, 9) == 0) return $urandom;
    if ($urandom_range(0, 9) == 0) return clip32(lo);
    if ($urandom_range(0, 9) == 0) return clip32(hi);
    span = (hi > lo) ? hi - lo : 1;
    p = lo + ((longint'($urandom) << 16 | $urandom_range(0, 65535)) % (span + span / 4 + 2))
        - span / 8 - 1;
    return clip32(p);
  endfunction

  // Run one phase: reload some cells, fill every reachable corner, then sample.
  task automatic run_phase(int ph);
    longint c, rw, rx, ry;
    int used, n_loads;
    set_geometry(ph);
    c  = (grid_cols_m > gbs_pkg::MAX_COLS) ? gbs_pkg::MAX_COLS : grid_cols_m;
    rw = (grid_rows_m > gbs_pkg::MAX_ROWS) ? gbs_pkg::MAX_ROWS : grid_rows_m;
    used = int'(c * rw);
    if (used < 2) used = 2;
    n_loads = (used > LOAD_CAP) ? LOAD_CAP : used;
    for (int i = 0; i < n_loads; i++)
      send_plain(mk_load($urandom_range(0, used - 1), rand_height()));
    // Fill any corner a sample can reach that was never written.
    if (c >= 2 && rw >= 2 && step_x_m > 0 && step_y_m > 0) begin
      rx = (x_hi_m > x_lo_m) ? (x_hi_m - x_lo_m) / step_x_m : 0;
      ry = (y_hi_m > y_lo_m) ? (y_hi_m - y_lo_m) / step_y_m : 0;
      if (rx > c - 2) rx = c - 2;
      if (ry > rw - 2) ry = rw - 2;
      for (longint r = 0; r <= ry + 1; r++)
        for (longint k = 0; k <= rx + 1; k++)
          if (!loaded[r * c + k]) send_plain(mk_load(int'(r * c + k), rand_height()));
    end
    drain();
    for (int i = 0; i < SAMPLES_PER; i++)
      send_plain(mk_sample(rand_pos(x_lo_m, x_hi_m), rand_pos(y_lo_m, y_hi_m)));
    drain();
  endtask

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    gbs_pkg::gbs_out_t want;
    if (rst_n && out_strobe) begin
      if (pending_samples.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item %h", $time, out_data);
      end else begin
        want = pending_samples.pop_front();
        if (out_data.height !== want.height) begin
          errors++;
          $display("%0t: height exp %h got %h", $time, want.height, out_data.height);
        end
        if (out_data.slope_x !== want.slope_x) begin
          errors++;
          $display("%0t: slope_x exp %h got %h", $time, want.slope_x, out_data.slope_x);
        end
        if (out_data.slope_y !== want.slope_y) begin
          errors++;
          $display("%0t: slope_y exp %h got %h", $time, want.slope_y, out_data.slope_y);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    grid_cols_m = 0; grid_rows_m = 0; step_x_m = 0; step_y_m = 0;
    x_lo_m = 0; x_hi_m = 0; y_lo_m = 0; y_hi_m = 0;
    for (int i = 0; i < gbs_pkg::GRID_DEPTH; i++) begin
      heights[i] = 0;
      loaded[i]  = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset the geometry is invalid: every sample reads all zeros.
    add_row(mk_sample(0, 0), 1'b1, '0);
    add_row(mk_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b1, '0);
    add_row(mk_sample(32'h8000_0000, 32'h8000_0000), 1'b1, '0);
    add_row(mk_sample(32'h7FFF_FFFF, 32'h8000_0000), 1'b1, '0);
    add_row(mk_load(0, 32'h7FFF_FFFF), 1'b0, '0);
    add_row(mk_load(4095, 32'h8000_0000), 1'b0, '0);
    add_row(mk_load(1, 0), 1'b0, '0);
    add_row(mk_load(2048, -1), 1'b0, '0);
    add_row(mk_sample(-1, 1), 1'b1, '0);
    add_row(mk_sample(32'h0001_0000, -32'h0001_0000), 1'b1, '0);
    foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      calm = (ph == N_PHASES - 1);
      run_phase(ph);
    end

    if (errors == 0 && pending_samples.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/gbs_pkg.sv
hw/rtl/gbs_ram.sv
hw/rtl/gbs_locate.sv
hw/rtl/gbs_slope.sv
hw/rtl/grid_bilinear_sample_gradient_top.sv
tb/sv/grid_bilinear_sample_gradient_top_tb.sv
